@@ rtl/u2u8_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and UTF-8 encoding functions for the UTF-16 to UTF-8 transcoder.
// Depends on nothing; every other file in rtl/ imports this package.

package u2u8_pkg;

  // Surrogate ranges and code point constants.
  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [20:0] TWO_BYTE_MIN   = 21'h000080;
  localparam logic [20:0] THREE_BYTE_MIN = 21'h000800;
  localparam logic [20:0] FOUR_BYTE_MIN  = 21'h010000;

  // UTF-8 lead and continuation markers.
  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] LEAD4    = 8'hF0;
  localparam logic [7:0] CONT     = 8'h80;
  localparam logic [5:0] CONT_MSK = 6'h3F;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  // Default depth of the job queue between the front and back halves.
  localparam int unsigned JOB_FIFO_DEPTH = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_last;
  } unit_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_end;
    logic [15:0] replaced_count;
  } result_t;

  // One classified code unit: an optional leading U+FFFD, then an optional code
  // point. A job with neither is a bare end of string.
  typedef struct packed {
    logic        rep_first;
    logic        cp_valid;
    logic [20:0] cp;
    logic        last;
    logic [15:0] tally;
  } job_t;

  // Number of UTF-8 bytes for a code point, minus one.
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp < TWO_BYTE_MIN) begin
      n = 2'd0;
    end else if (cp < THREE_BYTE_MIN) begin
      n = 2'd1;
    end else if (cp < FOUR_BYTE_MIN) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Byte number idx of the UTF-8 form of cp.
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [7:0] b;
    logic [1:0] len_m1;
    len_m1 = utf8_len_m1(cp);
    b = 8'h00;
    case (len_m1)
      2'd0: begin
        b = cp[7:0];
      end
      2'd1: begin
        b = (idx == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0] & CONT_MSK});
      end
      2'd2: begin
        case (idx)
          2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0] & CONT_MSK};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = CONT | {2'b00, cp[17:12]};
          2'd2:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0] & CONT_MSK};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

@@ rtl/u2u8_front.sv @@
`timescale 1ns / 1ps
// Front half of the transcoder: pairs surrogates, counts replacements and
// turns each accepted code unit that does not only park a high surrogate into a job. Depends on u2u8_pkg.

module u2u8_front
  import u2u8_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  unit_t unit_i,
  output logic  job_push_o,
  output job_t  job_o
);

  logic        held_q, held_d;
  logic [9:0]  held_bits_q, held_bits_d;
  logic [15:0] tally_q, tally_d;

  logic        is_high, is_low, fresh;
  logic [1:0]  reps;
  logic [16:0] tally_sum;
  logic [15:0] tally_sat;
  job_t        job;

  always_comb begin
    is_high = (unit_i.code_unit >= HIGH_SURR_LO) && (unit_i.code_unit <= HIGH_SURR_HI);
    is_low  = (unit_i.code_unit >= LOW_SURR_LO) && (unit_i.code_unit <= LOW_SURR_HI);
    fresh       = 1'b1;
    reps        = 2'd0;
    held_d      = held_q;
    held_bits_d = held_bits_q;
    job         = '0;
    job.last    = unit_i.unit_last;

    if (held_q) begin
      held_d      = 1'b0;
      held_bits_d = '0;
      if (is_low) begin
        job.cp       = SUPP_BASE + {1'b0, held_bits_q, unit_i.code_unit[9:0]};
        job.cp_valid = 1'b1;
        fresh        = 1'b0;
      end else begin
        job.rep_first = 1'b1;
        reps          = 2'd1;
      end
    end

    if (fresh) begin
      if (is_high) begin
        if (unit_i.unit_last) begin
          job.cp       = REPLACEMENT_CP;
          job.cp_valid = 1'b1;
          reps         = reps + 2'd1;
        end else begin
          held_d      = 1'b1;
          held_bits_d = unit_i.code_unit[9:0];
        end
      end else if (is_low) begin
        job.cp       = REPLACEMENT_CP;
        job.cp_valid = 1'b1;
        reps         = reps + 2'd1;
      end else if (!(unit_i.unit_last && (unit_i.code_unit == 16'h0000))) begin
        job.cp       = {5'b00000, unit_i.code_unit};
        job.cp_valid = 1'b1;
      end
    end

    tally_sum = {1'b0, tally_q} + {15'b0, reps};
    tally_sat = tally_sum[16] ? TALLY_MAX : tally_sum[15:0];
    job.tally = tally_sat;
    tally_d   = unit_i.unit_last ? '0 : tally_sat;
  end

  assign job_o      = job;
  assign job_push_o = accept_i && (job.rep_first || job.cp_valid || job.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      held_bits_q <= '0;
      tally_q     <= '0;
    end else if (accept_i) begin
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
      tally_q     <= tally_d;
    end
  end

endmodule

@@ rtl/u2u8_fifo.sv @@
`timescale 1ns / 1ps
// Short job queue between the front and back halves of the transcoder.
// Depends on u2u8_pkg for the job type.

module u2u8_fifo
  import u2u8_pkg::*;
#(
  parameter int unsigned Depth = JOB_FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == DepthCnt);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/u2u8_back.sv @@
`timescale 1ns / 1ps
// Back half of the transcoder: walks each job one UTF-8 byte per cycle into
// an output register while it is empty or popped. Depends on u2u8_pkg.

module u2u8_back
  import u2u8_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  input  job_t    job_i,
  output logic    job_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  logic       out_valid_q;
  result_t    out_q, out_d;
  logic [1:0] idx_q;
  logic       rep_done_q;

  logic       load;
  logic       in_rep;
  logic       bare;
  logic [20:0] cur_cp;
  logic       phase_end;
  logic       job_end;

  assign load   = job_valid_i && (!out_valid_q || pop_i);
  assign in_rep = job_i.rep_first && !rep_done_q;
  assign bare   = !job_i.rep_first && !job_i.cp_valid;
  assign cur_cp = in_rep ? REPLACEMENT_CP : job_i.cp;

  always_comb begin
    phase_end = bare || (idx_q == utf8_len_m1(cur_cp));
    job_end   = phase_end && !(in_rep && job_i.cp_valid);
    out_d                = '0;
    out_d.byte_valid     = !bare;
    out_d.out_byte       = bare ? 8'h00 : utf8_byte(cur_cp, idx_q);
    out_d.string_end     = job_end && job_i.last;
    out_d.replaced_count = (job_end && job_i.last) ? job_i.tally : 16'h0000;
  end

  assign job_pop_o = load && job_end;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      rep_done_q  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        if (job_end) begin
          idx_q      <= '0;
          rep_done_q <= 1'b0;
        end else if (phase_end) begin
          idx_q      <= '0;
          rep_done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

endmodule

@@ rtl/utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-16 to UTF-8 transcoder: front, job queue and back.
// Depends on u2u8_pkg, u2u8_front, u2u8_fifo and u2u8_back.
//
//   Channel   Handshake            Payload     Direction
//   input     push / full          unit_i      in   (one UTF-16 code unit)
//   result    empty / pop          result_o    out  (one UTF-8 byte or end marker)
//
// A code unit is classified in the cycle it is accepted and, unless it only
// parks a high surrogate, leaves one job in the queue. The first byte of that
// job reaches the result ports through the queue and then the output register.
// The back then sends one request per cycle unless the result stalls: 1 to 3 for
// a typical unit, 4 for a pair, and up to 6 when a broken pair puts U+FFFD
// ahead of a three-byte character or a second replacement; the byte-per-cycle
// output register sets the rate. Reset clears the held surrogate, the tally,
// the queue and the output valid flag. A stalled result holds; the front keeps
// accepting until the queue fills.

module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int unsigned JobDepth = JOB_FIFO_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  unit_t   unit_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_head;
  logic job_valid;
  logic job_pop;

  // A request is taken whenever the queue has room; units that only park a
  // high surrogate push nothing but are still accepted.
  assign accept = push && !full;

  u2u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .unit_i     (unit_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  u2u8_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .valid_o (job_valid),
    .full_o  (full)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

`ifndef NO_ASSERTIONS
  // A job with no bytes to send only ever closes a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && !job_head.rep_first && !job_head.cp_valid) |-> job_head.last)
    else $error("empty job that does not end a string");

  // A bare end marker is always the final request of its string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.byte_valid) |-> result_o.string_end)
    else $error("bare marker without string end");

  // The replacement count only appears on the final request of a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.string_end) |-> (result_o.replaced_count == 16'h0000))
    else $error("replacement count outside string end");

  // The front never pushes into a full queue, since it only works on accepted units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !full)
    else $error("job pushed into full queue");
`endif

endmodule
